>>> design/assert_macros.svh
// assertion macros used by pll_divider_search
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of i_clk, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked on every rising edge of i_clk, during reset too
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> design/pds_pkg.sv
// types, constants and the divider table of the pll divider search
package pds_pkg;

    localparam int FRAC_BITS = 17;
    localparam int QUO_BITS  = 33 + FRAC_BITS;
    localparam int DIV_STEPS = QUO_BITS;

    localparam logic [7:0]  FACTOR_FIRST  = 8'd1;
    localparam logic [7:0]  FACTOR_LAST   = 8'd255;
    localparam logic [13:0] MULT_INT_MAX  = 14'h3fff;
    localparam logic [3:0]  OD_COMBO_LAST = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic [1:0] CFG_MAX_PIX = 2'd0;
    localparam logic [1:0] CFG_VCO_MIN = 2'd1;
    localparam logic [1:0] CFG_VCO_MAX = 2'd2;
    localparam logic [1:0] CFG_REF_CLK = 2'd3;

    localparam logic [29:0] RST_MAX_PIX = 30'd500000000;
    localparam logic [32:0] RST_VCO_MIN = 33'd3000000000;
    localparam logic [32:0] RST_VCO_MAX = 33'd6000000000;
    localparam logic [26:0] RST_REF_CLK = 27'd24000000;

    typedef struct packed {
        logic [29:0] pixel_clock_hz;
        logic [31:0] lane_rate_max_hz;
    } t_pds_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  clk_ratio;
        logic [2:0]  od1_select;
        logic [2:0]  od2_select;
        logic [2:0]  od3_select;
        logic [13:0] multiplier_integer;
        logic [16:0] multiplier_fraction;
        logic [31:0] pll_rate_hz;
        logic [32:0] vco_frequency_hz;
    } t_pds_rsp;

    typedef struct packed {
        logic [2:0] od1_sel;
        logic [2:0] od2_sel;
        logic [2:0] od3_sel;
        logic [2:0] shift;
    } t_od_combo;

    // search order: od3 high to low, od2 <= od3, od1 <= od2
    function automatic t_od_combo od_combo(input logic [3:0] idx);
        t_od_combo c;
        case (idx)
            4'd0:    c = '{3'd2, 3'd2, 3'd2, 3'd6};
            4'd1:    c = '{3'd1, 3'd2, 3'd2, 3'd5};
            4'd2:    c = '{3'd0, 3'd2, 3'd2, 3'd4};
            4'd3:    c = '{3'd1, 3'd1, 3'd2, 3'd4};
            4'd4:    c = '{3'd0, 3'd1, 3'd2, 3'd3};
            4'd5:    c = '{3'd0, 3'd0, 3'd2, 3'd2};
            4'd6:    c = '{3'd1, 3'd1, 3'd1, 3'd3};
            4'd7:    c = '{3'd0, 3'd1, 3'd1, 3'd2};
            4'd8:    c = '{3'd0, 3'd0, 3'd1, 3'd1};
            4'd9:    c = '{3'd0, 3'd0, 3'd0, 3'd0};
            default: c = '{3'd0, 3'd0, 3'd0, 3'd0};
        endcase
        return c;
    endfunction

    // error results carry the status and zeros elsewhere
    function automatic t_pds_rsp err_rsp(input logic [1:0] status);
        t_pds_rsp r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

endpackage

>>> design/pds_div.sv
// restoring divider: vco scaled by the fraction width over the reference clock
module pds_div
    import pds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [32:0]         i_dividend,
    input  logic [26:0]         i_divisor,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [26:0]         r_rem;
    logic [QUO_BITS-1:0] r_quo;

    logic [27:0] shifted;
    logic [28:0] diff;
    logic        ge;

    assign shifted = {r_rem, r_quo[QUO_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};
    assign ge      = !diff[28];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= {i_dividend, {FRAC_BITS{1'b0}}};
            end else if (r_busy) begin
                r_rem <= ge ? diff[26:0] : shifted[26:0];
                r_quo <= {r_quo[QUO_BITS-2:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/pll_divider_search.sv
// top level of the pll divider search: sequencer, config registers, result register
//
// A request is taken on the rising edge where start is high and busy is low;
// i_req carries the pixel clock and the maximum lane bit rate. busy stays high
// while the search runs, and no other request is taken meanwhile.
// The result shows on o_rsp, marked by o_done for exactly one cycle; the
// receiver cannot hold it off. busy is already low in that cycle, so the next
// request may be taken at the edge that ends it.
// A pixel clock above the limit gives its result in the cycle after the request.
// Otherwise each clock factor is tried in turn, plus checks of the ten divider
// combinations when its product falls in the lane-rate window, one shift-compare per
// cycle; a hit starts a 50-step serial divider, whose quotient gives the multiplier
// in the registered result.
// The longest search is when pixel clock and lane rate are both zero,
// so every factor lands in the window and no divider fits.
// Configuration is written on i_cfg_we through i_cfg_addr and i_cfg_wdata; the user
// must write it only while no request is in flight, which the block does not enforce.
// A synchronous reset on i_rst_n loads the default limits and returns idle.
`include "assert_macros.svh"

module pll_divider_search
    import pds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_pds_req    i_req,
    output logic        o_done,
    output t_pds_rsp    o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [32:0] i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FACT = 2'd1;
    localparam logic [1:0] S_OD   = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]  r_state;
    logic [29:0] r_max_pix;
    logic [32:0] r_vco_min;
    logic [32:0] r_vco_max;
    logic [26:0] r_ref;
    logic [29:0] r_pix;
    logic [31:0] r_lane;
    logic [31:0] r_lo;
    logic [37:0] r_pll;
    logic [7:0]  r_factor;
    logic [3:0]  r_combo;
    t_od_combo   r_od;
    logic [32:0] r_vco;
    logic        r_done;
    t_pds_rsp    r_rsp;

    logic                accept;
    logic                in_window;
    t_od_combo           combo;
    logic [37:0]         vco_full;
    logic                vco_hit;
    logic                div_start;
    logic                div_done;
    logic [QUO_BITS-1:0] quotient;
    logic [13:0]         mult_int;
    logic [16:0]         mult_frac;
    t_pds_rsp            ok_rsp;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign in_window = (r_pll >= {6'd0, r_lo}) && (r_pll <= {6'd0, r_lane});
    assign combo     = od_combo(r_combo);
    assign vco_full  = {6'd0, r_pll[31:0]} << combo.shift;
    assign vco_hit   = (vco_full >= {5'd0, r_vco_min}) && (vco_full <= {5'd0, r_vco_max});
    assign div_start = (r_state == S_OD) && vco_hit;

    always_comb begin
        if (r_ref == '0) begin
            mult_int  = MULT_INT_MAX;
            mult_frac = '0;
        end else begin
            // integer part saturates once any bit above the field is set
            mult_int  = (quotient[QUO_BITS-1:FRAC_BITS+14] != '0) ? MULT_INT_MAX
                                                                  : quotient[FRAC_BITS+13:FRAC_BITS];
            mult_frac = quotient[FRAC_BITS-1:0];
        end
    end

    always_comb begin
        ok_rsp                     = '0;
        ok_rsp.status              = ST_OK;
        ok_rsp.clk_ratio           = r_factor;
        ok_rsp.od1_select          = r_od.od1_sel;
        ok_rsp.od2_select          = r_od.od2_sel;
        ok_rsp.od3_select          = r_od.od3_sel;
        ok_rsp.multiplier_integer  = mult_int;
        ok_rsp.multiplier_fraction = mult_frac;
        ok_rsp.pll_rate_hz         = r_pll[31:0];
        ok_rsp.vco_frequency_hz    = r_vco;
    end

    pds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (vco_full[32:0]),
        .i_divisor  (r_ref),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_max_pix <= RST_MAX_PIX;
            r_vco_min <= RST_VCO_MIN;
            r_vco_max <= RST_VCO_MAX;
            r_ref     <= RST_REF_CLK;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_PIX: r_max_pix <= i_cfg_wdata[29:0];
                    CFG_VCO_MIN: r_vco_min <= i_cfg_wdata;
                    CFG_VCO_MAX: r_vco_max <= i_cfg_wdata;
                    CFG_REF_CLK: r_ref     <= i_cfg_wdata[26:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pix    <= i_req.pixel_clock_hz;
                        r_lane   <= i_req.lane_rate_max_hz;
                        r_lo     <= (i_req.lane_rate_max_hz >= {2'b00, i_req.pixel_clock_hz})
                                    ? i_req.lane_rate_max_hz - {2'b00, i_req.pixel_clock_hz}
                                    : '0;
                        r_pll    <= {8'd0, i_req.pixel_clock_hz};
                        r_factor <= FACTOR_FIRST;
                        if (i_req.pixel_clock_hz > r_max_pix) begin
                            r_rsp  <= err_rsp(ST_RANGE);
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_FACT;
                        end
                    end
                end
                S_FACT: begin
                    if (in_window) begin
                        r_combo <= '0;
                        r_state <= S_OD;
                    end else if (r_factor == FACTOR_LAST) begin
                        r_rsp   <= err_rsp(ST_NOFIT);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_factor <= r_factor + 8'd1;
                        r_pll    <= r_pll + {8'd0, r_pix};
                    end
                end
                S_OD: begin
                    if (vco_hit) begin
                        r_od    <= combo;
                        r_vco   <= vco_full[32:0];
                        r_state <= S_DIV;
                    end else if (r_combo != OD_COMBO_LAST) begin
                        r_combo <= r_combo + 4'd1;
                    end else if (r_factor == FACTOR_LAST) begin
                        r_rsp   <= err_rsp(ST_NOFIT);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        // no divider fits, move on to the next factor
                        r_factor <= r_factor + 8'd1;
                        r_pll    <= r_pll + {8'd0, r_pix};
                        r_state  <= S_FACT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_rsp   <= ok_rsp;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ASSERT_CLK(a_done_idle, o_done |-> !busy, "result strobe while still busy")
    `ASSERT_CLK(a_range_fast,
        (accept && (i_req.pixel_clock_hz > r_max_pix)) |=> (o_done && o_rsp.status == ST_RANGE),
        "pixel clock above limit not reported in one cycle")
    `ASSERT_CLK(a_err_zero,
        (o_done && o_rsp.status != ST_OK) |->
            (o_rsp.clk_ratio == '0 && o_rsp.vco_frequency_hz == '0 &&
             o_rsp.pll_rate_hz == '0 && o_rsp.multiplier_integer == '0),
        "error result carries nonzero fields")
    `ASSERT_CLK(a_vco_window,
        (o_done && o_rsp.status == ST_OK) |->
            (o_rsp.vco_frequency_hz >= r_vco_min && o_rsp.vco_frequency_hz <= r_vco_max),
        "reported vco outside the window")
    `ASSERT_CLK(a_div_only_searching, div_done |-> (r_state == S_DIV),
        "divider finished outside the divide step")

endmodule
